// ----- rtl/emg_flex_envelope_detector_unit_macros.svh -----
// Assertion macros used by the envelope detector checker.
`ifndef EMG_FLEX_ENVELOPE_DETECTOR_UNIT_MACROS_SVH
`define EMG_FLEX_ENVELOPE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EFED_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication checked in the next cycle.
`define EFED_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/efed_pkg.sv -----
// Types and constants of the EMG flex envelope detector.
`default_nettype none
package efed_pkg;

  localparam int SAMPLE_W = 12;
  localparam int FRAC_W   = 16;
  localparam int LVL_W    = SAMPLE_W + FRAC_W;   // Q12.16 level
  localparam int OPND_W   = 30;                  // signed multiplier operand
  localparam int COEF_W   = 15;
  localparam int PROD_W   = OPND_W + COEF_W + 1;
  localparam int AMP_W    = 32;
  localparam int HIST_N   = 4;

  localparam logic [COEF_W-1:0] COEF_LP   = 15'd13107;  // 0.2
  localparam logic [COEF_W-1:0] COEF_HP   = 15'd6553;   // 0.1
  localparam logic [COEF_W-1:0] COEF_UP   = 15'd19660;  // 0.3
  localparam logic [COEF_W-1:0] COEF_DOWN = 15'd6553;   // 0.1

  localparam logic [SAMPLE_W-1:0] IDLE_RAW  = 12'd1930;
  localparam logic [SAMPLE_W-1:0] OUT_RESET = 12'd80;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_AMP_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HOLD_LENGTH   = 3'd1;
  localparam logic [2:0] REG_ACTIVE_TARGET = 3'd2;
  localparam logic [2:0] REG_REST_TARGET   = 3'd3;
  localparam logic [2:0] REG_WARMUP_OUTPUT = 3'd4;

  localparam logic [7:0]          RST_AMP_THRESHOLD = 8'd3;
  localparam logic [7:0]          RST_HOLD_LENGTH   = 8'd15;
  localparam logic [SAMPLE_W-1:0] RST_ACTIVE_TARGET = 12'd4095;
  localparam logic [SAMPLE_W-1:0] RST_REST_TARGET   = 12'd80;
  localparam logic [SAMPLE_W-1:0] RST_WARMUP_OUTPUT = 12'd130;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_LP_MUL,
    ST_LP_ST,
    ST_HP_PREP,
    ST_HP_MUL,
    ST_HP_ST,
    ST_AMP,
    ST_TGT,
    ST_OUT_MUL,
    ST_OUT_ST,
    ST_DONE
  } efed_state_t;

  typedef struct packed {
    logic in_valid;
    logic warm;
    logic out_free;
  } efed_stat_t;

  typedef struct packed {
    efed_state_t state;
    logic        accept;
    logic        load_out;
  } efed_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/emg_flex_envelope_detector_unit.sv -----
// Top level of the EMG flex envelope detector.
// A sample request is accepted in an idle cycle. The sequencer then walks
// three constant multiplies (low-pass, high-pass, output smoothing) through
// one shared multiplier, each followed by its store step, and loads the
// result into the output register once that register is free; while the
// ring is still warming up it skips the multiply steps. The next request
// can be accepted in the cycle after the result is loaded, so one sample
// holds the block until then. in_stall is high while a sample is being
// worked and while its result waits for a free output register.
// The output register holds one finished result, so a new sample can be
// accepted while the previous result waits to be taken. No clearing pass
// is needed after reset: unwritten ring entries read as zero until the ring
// has filled once.
`default_nettype none
module emg_flex_envelope_detector_unit import efed_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [SAMPLE_W-1:0] envelope_level,
  output logic                     warming_up,
  output logic                     hold_active,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int SUM_W = SAMPLE_W + PTR_W;
  localparam int FLX_W = SUM_W + 2;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
  localparam logic signed [FLX_W-1:0] DEP    = FLX_W'(RING_DEPTH);
  localparam logic signed [FLX_W-1:0] DEP_3  = FLX_W'(3 * RING_DEPTH);
  localparam logic signed [FLX_W-1:0] DEP_5  = FLX_W'(5 * RING_DEPTH);
  localparam logic signed [FLX_W-1:0] DEP_10 = FLX_W'(10 * RING_DEPTH);

  // configuration
  logic [7:0]          amp_threshold;
  logic [7:0]          hold_length;
  logic [SAMPLE_W-1:0] active_target;
  logic [SAMPLE_W-1:0] rest_target;
  logic [SAMPLE_W-1:0] warmup_output;

  // datapath state
  logic [SAMPLE_W-1:0]      x;
  logic [PTR_W-1:0]         ring_pointer;
  logic [SUM_W-1:0]         ring_sum;
  logic                     ring_filled;
  logic [SAMPLE_W-1:0]      hist [HIST_N];
  logic [LVL_W-1:0]         smooth_level;
  logic [LVL_W-1:0]         previous_smooth;
  logic signed [OPND_W-1:0] highpass_level;
  logic [LVL_W-1:0]         output_level;
  logic [7:0]               hold_counter;
  logic signed [OPND_W-1:0] opnd;
  logic [AMP_W-1:0]         amp;
  logic                     going_up;
  logic                     warm;

  efed_stat_t stat;
  efed_ctl_t  ctl;

  logic [SAMPLE_W-1:0]      ram_rdata;
  logic [SAMPLE_W-1:0]      old_sample;
  logic                     ptr_last;
  logic                     mul_en;
  logic [COEF_W-1:0]        mul_coef;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] prod_hi;
  logic signed [OPND_W-1:0] smooth_sum;
  logic signed [OPND_W-1:0] out_sum;
  logic [OPND_W-1:0]        hp_abs;
  logic signed [FLX_W-1:0]  s_ext, v0d, v1d, v2d;
  logic                     flex;
  logic                     active;
  logic signed [OPND_W-1:0] act_diff, rest_diff;
  logic                     cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (ctl.state != ST_IDLE);

  assign ptr_last   = (ring_pointer == LAST_SLOT);
  assign old_sample = ring_filled ? ram_rdata : '0;

  assign stat.in_valid = in_valid;
  assign stat.warm     = !ring_filled && !ptr_last;
  assign stat.out_free = !out_valid || !out_stall;

  efed_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  efed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.state == ST_SUM),
    .waddr (ring_pointer),
    .wdata (x),
    .raddr (ring_pointer),
    .rdata (ram_rdata)
  );

  always_comb begin
    mul_en   = 1'b1;
    mul_coef = COEF_LP;
    case (ctl.state)
      ST_LP_MUL:  mul_coef = COEF_LP;
      ST_HP_MUL:  mul_coef = COEF_HP;
      ST_OUT_MUL: mul_coef = going_up ? COEF_UP : COEF_DOWN;
      default:    mul_en   = 1'b0;
    endcase
  end

  efed_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (opnd),
    .c    (mul_coef),
    .prod (prod)
  );

  // product >> 16, floor
  assign prod_hi    = prod[PROD_W-1:FRAC_W];
  assign smooth_sum = $signed({2'b00, smooth_level}) + prod_hi;
  assign out_sum    = $signed({2'b00, output_level}) + prod_hi;
  assign hp_abs     = highpass_level[OPND_W-1] ? OPND_W'(-highpass_level)
                                               : highpass_level;

  // flex pattern against the ring mean, scaled by the depth
  assign s_ext = $signed(FLX_W'(ring_sum));
  assign v0d   = $signed(FLX_W'(hist[0])) * DEP;
  assign v1d   = $signed(FLX_W'(hist[1])) * DEP;
  assign v2d   = $signed(FLX_W'(hist[2])) * DEP;
  assign flex  = (v0d >= s_ext - DEP_5) && (v0d <= s_ext + DEP_5) &&
                 (v1d > s_ext + DEP_3) && (v2d < s_ext - DEP_10) &&
                 (hist[3] > hist[2]);

  assign active    = (hold_counter != 8'd0) ||
                     (amp > AMP_W'({amp_threshold, {FRAC_W{1'b0}}}));
  assign act_diff  = $signed({2'b00, active_target, {FRAC_W{1'b0}}}) -
                     $signed({2'b00, output_level});
  assign rest_diff = $signed({2'b00, rest_target, {FRAC_W{1'b0}}}) -
                     $signed({2'b00, output_level});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amp_threshold <= RST_AMP_THRESHOLD;
      hold_length   <= RST_HOLD_LENGTH;
      active_target <= RST_ACTIVE_TARGET;
      rest_target   <= RST_REST_TARGET;
      warmup_output <= RST_WARMUP_OUTPUT;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_AMP_THRESHOLD: amp_threshold <= pwdata[7:0];
        REG_HOLD_LENGTH:   hold_length   <= pwdata[7:0];
        REG_ACTIVE_TARGET: active_target <= pwdata[SAMPLE_W-1:0];
        REG_REST_TARGET:   rest_target   <= pwdata[SAMPLE_W-1:0];
        REG_WARMUP_OUTPUT: warmup_output <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_AMP_THRESHOLD: prdata = DATA_W'(amp_threshold);
      REG_HOLD_LENGTH:   prdata = DATA_W'(hold_length);
      REG_ACTIVE_TARGET: prdata = DATA_W'(active_target);
      REG_REST_TARGET:   prdata = DATA_W'(rest_target);
      REG_WARMUP_OUTPUT: prdata = DATA_W'(warmup_output);
      default:           prdata = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x <= sample;
    end
    case (ctl.state)
      ST_SUM:     opnd <= $signed({2'b00, x, {FRAC_W{1'b0}}}) -
                          $signed({2'b00, smooth_level});
      ST_HP_PREP: opnd <= highpass_level + $signed({2'b00, smooth_level}) -
                          $signed({2'b00, previous_smooth});
      ST_AMP:     amp  <= (AMP_W'(hp_abs) << 4) + (AMP_W'(hp_abs) << 2);
      ST_TGT: begin
        opnd     <= active ? act_diff : rest_diff;
        going_up <= active;
      end
      default: ;
    endcase
  end

  // filter, ring and hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer    <= '0;
      ring_sum        <= '0;
      ring_filled     <= 1'b0;
      for (int i = 0; i < HIST_N; i++) begin
        hist[i] <= IDLE_RAW;
      end
      smooth_level    <= {IDLE_RAW, {FRAC_W{1'b0}}};
      previous_smooth <= {IDLE_RAW, {FRAC_W{1'b0}}};
      highpass_level  <= '0;
      output_level    <= {OUT_RESET, {FRAC_W{1'b0}}};
      hold_counter    <= '0;
      warm            <= 1'b0;
    end else begin
      case (ctl.state)
        ST_SUM: begin
          ring_sum     <= ring_sum - SUM_W'(old_sample) + SUM_W'(x);
          ring_pointer <= ptr_last ? '0 : ring_pointer + 1'b1;
          if (ptr_last) begin
            ring_filled <= 1'b1;
          end
          for (int i = 0; i < HIST_N - 1; i++) begin
            hist[i] <= hist[i+1];
          end
          hist[HIST_N-1] <= x;
          warm <= stat.warm;
        end
        ST_LP_ST: smooth_level <= smooth_sum[LVL_W-1:0];
        ST_HP_PREP: begin
          previous_smooth <= smooth_level;
          if (flex) begin
            hold_counter <= hold_length;
          end else if (hold_counter != 8'd0) begin
            hold_counter <= hold_counter - 8'd1;
          end
        end
        ST_HP_ST:  highpass_level <= prod_hi;
        ST_OUT_ST: output_level   <= out_sum[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      envelope_level <= warm ? warmup_output : output_level[LVL_W-1:FRAC_W];
      warming_up     <= warm;
      hold_active    <= (hold_counter != 8'd0);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/efed_ram.sv -----
// Generic single-port-write RAM with registered read.
`default_nettype none
module efed_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/efed_mul.sv -----
// Shared coefficient multiplier with registered product.
`default_nettype none
module efed_mul import efed_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [OPND_W-1:0] a,
  input  wire logic        [COEF_W-1:0] c,
  output logic      signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, c});
    end
  end

endmodule
`default_nettype wire

// ----- rtl/efed_ctrl.sv -----
// Step sequencer of the envelope detector.
`default_nettype none
module efed_ctrl import efed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire efed_stat_t stat,
  output efed_ctl_t       ctl
);

  efed_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.state    = state;
    ctl.accept   = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM:     state_next = stat.warm ? ST_DONE : ST_LP_MUL;
      ST_LP_MUL:  state_next = ST_LP_ST;
      ST_LP_ST:   state_next = ST_HP_PREP;
      ST_HP_PREP: state_next = ST_HP_MUL;
      ST_HP_MUL:  state_next = ST_HP_ST;
      ST_HP_ST:   state_next = ST_AMP;
      ST_AMP:     state_next = ST_TGT;
      ST_TGT:     state_next = ST_OUT_MUL;
      ST_OUT_MUL: state_next = ST_OUT_ST;
      ST_OUT_ST:  state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/efed_checker.sv -----
// Port-level checker for the envelope detector, bound to the top level.
`default_nettype none
`include "emg_flex_envelope_detector_unit_macros.svh"
module efed_checker import efed_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [SAMPLE_W-1:0] envelope_level,
  input wire logic                warming_up,
  input wire logic                hold_active
);

  // held result stays put
  `EFED_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(envelope_level) && $stable(warming_up) && $stable(hold_active), "stalled result changed")

  // one request at a time
  `EFED_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second request taken while busy")

  // no hold is reported during warm-up
  `EFED_ASSERT_IMP(a_warm_no_hold, out_valid && warming_up, !hold_active, "hold reported during warm-up")

  // a fresh result only follows work in progress
  `EFED_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall), "result without a request")

endmodule

bind emg_flex_envelope_detector_unit efed_checker u_efed_checker (.*);
`default_nettype wire
